### rtl/core/job_slot_table_round_robin_top_defines.svh
// ----------------------------------------------------------------------------
// Job slot table assertion macros
// Shared property forms for the interface checker of the job slot table.
// ----------------------------------------------------------------------------
`ifndef JOB_SLOT_TABLE_ROUND_ROBIN_TOP_DEFINES_SVH
`define JOB_SLOT_TABLE_ROUND_ROBIN_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define JST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define JST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/jst_pkg.sv
// ----------------------------------------------------------------------------
// Job slot table package
// Field widths, operation codes, controller states and the command and status
// groups shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int SLOT_COUNT_DEF   = 16;
  localparam int TAG_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int FIELD_W = 32;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_TAKE   = 2'd1,
    OP_RECALL = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic ins_write;
    logic set_full;
    logic take_hit;
    logic rd_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cur_valid;
    logic last;
  } sts_t;

endpackage

### rtl/core/jst_ctrl.sv
// ----------------------------------------------------------------------------
// Job slot table controller
// Sequences the one-slot-per-cycle scan for insert, take and recall requests.
// ----------------------------------------------------------------------------
module jst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  jst_pkg::sts_t sts,
  output jst_pkg::cmd_t cmd,
  output logic          busy
);
  import jst_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        unique case (sts.op)
          OP_INSERT: begin
            if (!sts.cur_valid) begin
              cmd.ins_write = 1'b1;
              state_next    = ST_DONE;
            end else if (sts.last) begin
              cmd.set_full = 1'b1;
              state_next   = ST_DONE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          OP_TAKE: begin
            if (sts.cur_valid) begin
              cmd.take_hit = 1'b1;
              cmd.rd_en    = 1'b1;
              state_next   = ST_DONE;
            end else if (sts.last) begin
              state_next = ST_DONE;
            end else begin
              cmd.step = 1'b1;
            end
          end
          OP_RECALL: begin
            cmd.rd_en = 1'b1;
            if (sts.last) begin
              state_next = ST_DRAIN;
            end else begin
              cmd.step = 1'b1;
            end
          end
          OP_NOP: begin
            state_next = ST_DONE;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/jst_datapath.sv
// ----------------------------------------------------------------------------
// Job slot table datapath
// Slot memory, valid bits, scan pointer, job count and the result registers.
// ----------------------------------------------------------------------------
module jst_datapath #(
  parameter int SLOT_COUNT   = jst_pkg::SLOT_COUNT_DEF,
  parameter int TAG_BITS     = jst_pkg::TAG_BITS_DEF,
  parameter int PAYLOAD_BITS = jst_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  jst_pkg::cmd_t                cmd,
  output jst_pkg::sts_t                sts,
  input  logic [jst_pkg::OP_W-1:0]     operation,
  input  logic [jst_pkg::FIELD_W-1:0]  owner_tag,
  input  logic [jst_pkg::FIELD_W-1:0]  job_payload,
  output logic                         done,
  output logic                         success,
  output logic                         table_full,
  output logic [jst_pkg::SLOT_W-1:0]   slot_index,
  output logic [jst_pkg::FIELD_W-1:0]  taken_tag,
  output logic [jst_pkg::FIELD_W-1:0]  taken_payload,
  output logic [jst_pkg::COUNT_W-1:0]  recalled_count,
  output logic [jst_pkg::COUNT_W-1:0]  pending_jobs
);
  import jst_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic [TAG_BITS-1:0]     mem_tag [SLOT_COUNT];
  logic [PAYLOAD_BITS-1:0] mem_pay [SLOT_COUNT];

  logic [SLOT_COUNT-1:0]   valid;
  op_t                     op_q;
  logic [TAG_BITS-1:0]     tag_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [IDX_W-1:0]        pos;
  logic [IDX_W-1:0]        cnt;
  logic [IDX_W-1:0]        scan_start;
  logic [CNT_W-1:0]        job_total;
  logic [CNT_W-1:0]        n_rec;
  logic                    res_success;
  logic                    res_full;
  logic [IDX_W-1:0]        res_slot;
  logic                    rd_vld;
  logic [IDX_W-1:0]        rd_pos;
  logic [TAG_BITS-1:0]     rd_tag;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  logic                    cmp_hit;
  logic                    take_ok;
  logic [CNT_W-1:0]        job_final;

  assign cmp_hit   = rd_vld && (op_q == OP_RECALL) && valid[rd_pos] && (rd_tag == tag_q);
  assign take_ok   = (op_q == OP_TAKE) && res_success;
  assign job_final = (op_q == OP_RECALL) ? (job_total - n_rec) : job_total;

  assign sts.op        = op_q;
  assign sts.cur_valid = valid[pos];
  assign sts.last      = (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      mem_tag[pos] <= tag_q;
      mem_pay[pos] <= pay_q;
    end
    if (cmd.rd_en) begin
      rd_tag <= mem_tag[pos];
      rd_pay <= mem_pay[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      op_q        <= OP_NOP;
      pos         <= '0;
      cnt         <= '0;
      scan_start  <= '0;
      job_total   <= '0;
      n_rec       <= '0;
      res_success <= 1'b0;
      res_full    <= 1'b0;
      res_slot    <= '0;
      rd_vld      <= 1'b0;
      done        <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      done   <= cmd.finish;
      if (cmd.load) begin
        op_q        <= op_t'(operation);
        pos         <= (op_t'(operation) == OP_TAKE) ? scan_start : '0;
        cnt         <= '0;
        n_rec       <= '0;
        res_success <= 1'b0;
        res_full    <= 1'b0;
        res_slot    <= '0;
      end else if (cmd.step) begin
        cnt <= cnt + 1'b1;
        pos <= (pos == LAST_IDX) ? '0 : pos + 1'b1;
      end
      if (cmd.ins_write) begin
        valid[pos]  <= 1'b1;
        job_total   <= job_total + 1'b1;
        res_success <= 1'b1;
        res_slot    <= pos;
      end else if (cmd.take_hit) begin
        valid[pos]  <= 1'b0;
        job_total   <= job_total - 1'b1;
        scan_start  <= pos;
        res_success <= 1'b1;
        res_slot    <= pos;
      end else if (cmp_hit) begin
        valid[rd_pos] <= 1'b0;
        n_rec         <= n_rec + 1'b1;
      end else if (cmd.finish) begin
        job_total <= job_final;
      end
      if (cmd.set_full) begin
        res_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_q <= TAG_BITS'(owner_tag);
      pay_q <= PAYLOAD_BITS'(job_payload);
    end
    rd_pos <= pos;
    if (cmd.finish) begin
      success        <= (op_q == OP_RECALL) ? (n_rec != '0) : res_success;
      table_full     <= res_full;
      slot_index     <= SLOT_W'(res_slot);
      taken_tag      <= take_ok ? FIELD_W'(rd_tag) : '0;
      taken_payload  <= take_ok ? FIELD_W'(rd_pay) : '0;
      recalled_count <= COUNT_W'(n_rec);
      pending_jobs   <= COUNT_W'(job_final);
    end
  end

endmodule

### rtl/core/job_slot_table_round_robin_top.sv
// ----------------------------------------------------------------------------
// Job slot table with round-robin take
// The done strobe shows when the scan ends: an insert or a take stops at the
// first slot it can use, while a recall scans every slot, one slot per cycle.
// A new request is accepted in the cycle that the done strobe shows, not
// before, so requests never overlap. The receiver cannot stall.
// Synchronous reset empties the table and clears the scan start and job count.
// ----------------------------------------------------------------------------
module job_slot_table_round_robin_top #(
  parameter int SLOT_COUNT   = jst_pkg::SLOT_COUNT_DEF,
  parameter int TAG_BITS     = jst_pkg::TAG_BITS_DEF,
  parameter int PAYLOAD_BITS = jst_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [jst_pkg::OP_W-1:0]     operation,
  input  logic [jst_pkg::FIELD_W-1:0]  owner_tag,
  input  logic [jst_pkg::FIELD_W-1:0]  job_payload,
  output logic                         done,
  output logic                         success,
  output logic                         table_full,
  output logic [jst_pkg::SLOT_W-1:0]   slot_index,
  output logic [jst_pkg::FIELD_W-1:0]  taken_tag,
  output logic [jst_pkg::FIELD_W-1:0]  taken_payload,
  output logic [jst_pkg::COUNT_W-1:0]  recalled_count,
  output logic [jst_pkg::COUNT_W-1:0]  pending_jobs
);
  import jst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  jst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  jst_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .TAG_BITS     (TAG_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .owner_tag      (owner_tag),
    .job_payload    (job_payload),
    .done           (done),
    .success        (success),
    .table_full     (table_full),
    .slot_index     (slot_index),
    .taken_tag      (taken_tag),
    .taken_payload  (taken_payload),
    .recalled_count (recalled_count),
    .pending_jobs   (pending_jobs)
  );

endmodule

### rtl/core/jst_checker.sv
// ----------------------------------------------------------------------------
// Job slot table interface checker
// Port-level properties of the request and result handshake.
// ----------------------------------------------------------------------------
`include "job_slot_table_round_robin_top_defines.svh"

module jst_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         success,
  input logic                         table_full,
  input logic [jst_pkg::SLOT_W-1:0]   slot_index,
  input logic [jst_pkg::FIELD_W-1:0]  taken_tag,
  input logic [jst_pkg::FIELD_W-1:0]  taken_payload
);
  import jst_pkg::*;

  `JST_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted request not busy")
  `JST_ASSERT_SAME(a_done_idle, done, !busy && $past(busy), "done strobe outside idle")
  `JST_ASSERT_SAME(a_full_excl, done, !(success && table_full), "success with table full")
  `JST_ASSERT_SAME(a_fail_zero, done && !success, (slot_index == '0) && (taken_tag == '0) && (taken_payload == '0), "failed request carries data")

endmodule

bind job_slot_table_round_robin_top jst_checker u_jst_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .success       (success),
  .table_full    (table_full),
  .slot_index    (slot_index),
  .taken_tag     (taken_tag),
  .taken_payload (taken_payload)
);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Job slot table testbench
// Sends insert, take, recall and unused-code requests to the slot table and
// predicts each done result with its own table model: lowest free slot on
// insert, circular scan from the last taken slot on take, tag match on recall.
// Every result field is compared in order against the predicted results.
// ----------------------------------------------------------------------------
module tb_top;
  import jst_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic               success;
    logic               table_full;
    logic [SLOT_W-1:0]  slot_index;
    logic [FIELD_W-1:0] taken_tag;
    logic [FIELD_W-1:0] taken_payload;
    logic [COUNT_W-1:0] recalled_count;
    logic [COUNT_W-1:0] pending_jobs;
  } job_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    operation = '0;
  logic [FIELD_W-1:0] owner_tag = '0;
  logic [FIELD_W-1:0] job_payload = '0;
  logic               done;
  logic               success;
  logic               table_full;
  logic [SLOT_W-1:0]  slot_index;
  logic [FIELD_W-1:0] taken_tag;
  logic [FIELD_W-1:0] taken_payload;
  logic [COUNT_W-1:0] recalled_count;
  logic [COUNT_W-1:0] pending_jobs;

  logic               tbl_valid [SLOTS];
  logic [FIELD_W-1:0] tbl_tag [SLOTS];
  logic [FIELD_W-1:0] tbl_payload [SLOTS];
  int                 rr_start;
  int                 job_count;

  job_result_t        pending_results[$];
  job_result_t        want;
  logic [FIELD_W-1:0] tag_pool [6];
  int                 idle_pct;
  int                 requests_sent;
  int                 results_checked;
  int                 mismatches;
  int                 full_inserts;
  int                 empty_takes;
  int                 recall_hits;
  int                 quiet_cycles;

  job_slot_table_round_robin_top i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic job_result_t predict_job_op(op_t op, logic [FIELD_W-1:0] tag,
                                                 logic [FIELD_W-1:0] pay);
    job_result_t r;
    int          pos;
    int          freed;
    r     = '{default: '0};
    freed = 0;
    case (op)
      OP_INSERT: begin
        r.table_full = 1'b1;
        for (int i = 0; i < SLOTS && !r.success; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i]   = 1'b1;
            tbl_tag[i]     = tag;
            tbl_payload[i] = pay;
            job_count++;
            r.success      = 1'b1;
            r.table_full   = 1'b0;
            r.slot_index   = i[SLOT_W-1:0];
          end
        end
        if (r.table_full) full_inserts++;
      end
      OP_TAKE: begin
        pos = rr_start;
        for (int n = 0; n < SLOTS && !r.success; n++) begin
          if (tbl_valid[pos]) begin
            tbl_valid[pos]  = 1'b0;
            if (job_count > 0) job_count--;
            rr_start        = pos;
            r.success       = 1'b1;
            r.slot_index    = pos[SLOT_W-1:0];
            r.taken_tag     = tbl_tag[pos];
            r.taken_payload = tbl_payload[pos];
          end else begin
            pos = (pos + 1) % SLOTS;
          end
        end
        if (!r.success) empty_takes++;
      end
      OP_RECALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_tag[i] == tag) begin
            tbl_valid[i] = 1'b0;
            freed++;
          end
        end
        job_count        = (job_count >= freed) ? job_count - freed : 0;
        r.recalled_count = freed[COUNT_W-1:0];
        r.success        = (freed > 0);
        if (freed > 0) recall_hits++;
      end
      default: begin
      end
    endcase
    r.pending_jobs = job_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_request(op_t op, logic [FIELD_W-1:0] tag, logic [FIELD_W-1:0] pay);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start       <= 1'b1;
    operation   <= op;
    owner_tag   <= tag;
    job_payload <= pay;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_job_op(op, tag, pay));
    requests_sent++;
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [FIELD_W-1:0] want_v,
                             logic [FIELD_W-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("done strobe with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("success", want.success, success);
        check_field("table_full", want.table_full, table_full);
        check_field("slot_index", want.slot_index, slot_index);
        check_field("taken_tag", want.taken_tag, taken_tag);
        check_field("taken_payload", want.taken_payload, taken_payload);
        check_field("recalled_count", want.recalled_count, recalled_count);
        check_field("pending_jobs", want.pending_jobs, pending_jobs);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request or result moved for %0d cycles.", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_empty_table();
    idle_pct = 0;
    send_request(OP_TAKE, 32'h0, 32'h0);
    send_request(OP_RECALL, 32'h0, 32'hffff_ffff);
    send_request(OP_NOP, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_fill_to_overflow();
    logic [FIELD_W-1:0] pattern [4] = '{32'h0, 32'hffff_ffff, 32'ha5a5_a5a5, 32'h5a5a_5a5a};
    for (int i = 0; i <= SLOTS; i++) begin
      send_request(OP_INSERT, pattern[i % 4], ~pattern[i % 4] ^ 32'(i));
    end
  endtask

  task automatic test_round_robin_and_recall();
    send_request(OP_TAKE, 32'h0, 32'h0);
    send_request(OP_TAKE, 32'h0, 32'h0);
    send_request(OP_RECALL, 32'hffff_ffff, 32'h0);
    send_request(OP_RECALL, 32'h1234_5678, 32'h0);
    send_request(OP_TAKE, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'h8000_0001, 32'h7fff_fffe);
  endtask

  task automatic test_pause_until_drained();
    wait_for_results();
  endtask

  task automatic test_random_traffic(int count, int pct_idle, int insert_pct);
    int                 roll;
    op_t                op;
    logic [FIELD_W-1:0] tag;
    idle_pct = pct_idle;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < insert_pct) op = OP_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) * 6 / 10) op = OP_TAKE;
      else if (roll < 96) op = OP_RECALL;
      else op = OP_NOP;
      tag = ($urandom_range(3) != 0) ? tag_pool[$urandom_range(5)] : $urandom();
      send_request(op, tag, $urandom());
    end
  endtask

  initial begin
    tag_pool = '{32'h0, 32'hffff_ffff, $urandom(), $urandom(), $urandom(), $urandom()};
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    rr_start  = 0;
    job_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_fill_to_overflow();
    test_round_robin_and_recall();
    test_random_traffic(110, 0, 60);
    test_pause_until_drained();
    test_random_traffic(110, 72, 35);
    test_random_traffic(110, 37, 55);
    test_pause_until_drained();
    test_random_traffic(110, 0, 45);

    wait_for_results();
    repeat (SLOTS + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    $display("Sent %0d requests and checked %0d results with idle gaps from none to heavy.",
             requests_sent, results_checked);
    $display("Inserts into a full table: %0d, takes from an empty table: %0d, recalls: %0d.",
             full_inserts, empty_takes, recall_hits);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
